@@ rtl/core/slt_pkg.sv @@
// Package for the shell line tokenizer: character classes, lexer states,
// line status codes and the item types passed between front and back.
// Depends on nothing; every module of the block imports it.
package slt_pkg;

  localparam logic [7:0] ChPipe  = 8'h7C;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChNul   = 8'h00;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    CLS_END   = 3'd0,
    CLS_QUOTE = 3'd1,
    CLS_BLANK = 3'd2,
    CLS_PIPE  = 3'd3,
    CLS_OTHER = 3'd4
  } char_class_e;

  typedef enum logic [2:0] {
    LX_START = 3'b001,
    LX_WORD  = 3'b010,
    LX_PIPE  = 3'b100
  } lex_state_e;

  typedef enum logic [1:0] {
    LS_CONTINUE = 2'd0,
    LS_ACCEPT   = 2'd1,
    LS_REJECT   = 2'd2
  } line_status_e;

  typedef struct packed {
    char_class_e cls;
    logic [7:0]  chr;
  } char_item_t;

  typedef struct packed {
    logic         token_closed;
    logic         closed_is_pipe;
    logic         char_kept;
    logic [7:0]   char_out;
    logic         starts_token;
    logic         kept_is_pipe;
    line_status_e line_status;
  } result_t;

  function automatic char_class_e classify(logic [7:0] c);
    char_class_e cls;
    if (c == ChNl || c == ChNul) begin
      cls = CLS_END;
    end else if (c == ChQuote) begin
      cls = CLS_QUOTE;
    end else if (c == ChSpace || c == ChTab) begin
      cls = CLS_BLANK;
    end else if (c == ChPipe) begin
      cls = CLS_PIPE;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

@@ rtl/core/slt_front.sv @@
// Front end of the shell line tokenizer: accepts characters, classifies
// them and holds them in a short queue for the back end.
// Depends on slt_pkg.
module slt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [7:0]         char_in_i,
  output logic               valid_o,
  output slt_pkg::char_item_t item_o,
  input  logic               take_i
);
  import slt_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  char_item_t      mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = valid_o && take_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q].cls <= classify(char_in_i);
      mem_q[wr_q].chr <= char_in_i;
    end
  end

endmodule

@@ rtl/core/slt_back.sv @@
// Back end of the shell line tokenizer: runs the lexer state and quote
// parity on classified characters and queues one result per item.
// Depends on slt_pkg.
module slt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  slt_pkg::char_item_t item_i,
  output logic                take_o,
  output logic                empty_o,
  input  logic                pop_i,
  output slt_pkg::result_t    result_o
);
  import slt_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  lex_state_e      state_q, state_d;
  logic            quote_q, quote_d;
  result_t         res;
  result_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign take_o   = valid_i && (cnt_q != CntW'(QueueDepth));
  assign empty_o  = (cnt_q == '0);
  assign result_o = mem_q[rd_q];
  assign do_pop   = !empty_o && pop_i;

  always_comb begin
    lex_state_e st;
    logic       q;
    st  = state_q;
    q   = quote_q;
    res = '0;
    res.line_status = LS_CONTINUE;
    if (st == LX_PIPE && q) begin
      st = LX_START;
    end
    case (st)
      LX_WORD: begin
        if (!q) begin
          case (item_i.cls)
            CLS_QUOTE: q = 1'b1;
            CLS_END: begin
              res.token_closed = 1'b1;
              res.line_status  = LS_ACCEPT;
            end
            CLS_BLANK: begin
              res.token_closed = 1'b1;
              st = LX_START;
            end
            CLS_PIPE: begin
              res.token_closed = 1'b1;
              res.char_kept    = 1'b1;
              res.starts_token = 1'b1;
              res.kept_is_pipe = 1'b1;
              st = LX_PIPE;
            end
            default: res.char_kept = 1'b1;
          endcase
        end else begin
          case (item_i.cls)
            CLS_END:   res.line_status = LS_REJECT;
            CLS_QUOTE: q = 1'b0;
            default:   res.char_kept = 1'b1;
          endcase
        end
      end
      LX_PIPE: begin
        res.token_closed   = 1'b1;
        res.closed_is_pipe = 1'b1;
        case (item_i.cls)
          CLS_END:   res.line_status = LS_ACCEPT;
          CLS_BLANK: st = LX_START;
          CLS_PIPE: begin
            res.char_kept    = 1'b1;
            res.starts_token = 1'b1;
            res.kept_is_pipe = 1'b1;
          end
          CLS_QUOTE: begin
            q  = 1'b1;
            st = LX_START;
          end
          default: begin
            res.char_kept    = 1'b1;
            res.starts_token = 1'b1;
            st = LX_WORD;
          end
        endcase
      end
      default: begin
        st = LX_START;
        case (item_i.cls)
          CLS_END:   res.line_status = LS_ACCEPT;
          CLS_QUOTE: q = !q;
          CLS_BLANK: ;
          CLS_PIPE: begin
            res.char_kept    = 1'b1;
            res.starts_token = 1'b1;
            if (!q) begin
              res.kept_is_pipe = 1'b1;
              st = LX_PIPE;
            end else begin
              st = LX_WORD;
            end
          end
          default: begin
            res.char_kept    = 1'b1;
            res.starts_token = 1'b1;
            st = LX_WORD;
          end
        endcase
      end
    endcase
    if (res.line_status != LS_CONTINUE) begin
      st = LX_START;
      q  = 1'b0;
    end
    res.char_out = res.char_kept ? item_i.chr : 8'h00;
    state_d = st;
    quote_d = q;
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (take_o) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (take_o && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !take_o) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LX_START;
      quote_q <= 1'b0;
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      if (take_o) begin
        state_q <= state_d;
        quote_q <= quote_d;
      end
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      mem_q[wr_q] <= res;
    end
  end

endmodule

@@ rtl/core/shell_line_tokenizer.sv @@
// Top level of the shell line tokenizer: front end and back end joined
// by a two-entry character queue. Depends on slt_pkg, slt_front, slt_back.
//
// One character enters per item and one result leaves per item, in order.
// The block sustains one item per clock cycle on both sides as long as
// the result queue is popped and full stays low; a character is first
// written into the front queue, and the lexer step reads it from there
// and writes its result into the result queue, from which it is popped.
// The rate is set by the combinational lexer step in the back end.
// Full rises when the front queue holds two items the back end could not
// take because its two-entry result queue is full; a newline or NUL ends
// the line and returns the lexer to its start state.
module shell_line_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  output logic       empty,
  input  logic       pop,
  output logic       token_closed_o,
  output logic       closed_is_pipe_o,
  output logic       char_kept_o,
  output logic [7:0] char_out_o,
  output logic       starts_token_o,
  output logic       kept_is_pipe_o,
  output logic [1:0] line_status_o
);
  import slt_pkg::*;

  logic       q_valid, q_take;
  char_item_t q_item;
  result_t    result;

  slt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .char_in_i (char_in_i),
    .valid_o   (q_valid),
    .item_o    (q_item),
    .take_i    (q_take)
  );

  slt_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .item_i   (q_item),
    .take_o   (q_take),
    .empty_o  (empty),
    .pop_i    (pop),
    .result_o (result)
  );

  assign token_closed_o   = result.token_closed;
  assign closed_is_pipe_o = result.closed_is_pipe;
  assign char_kept_o      = result.char_kept;
  assign char_out_o       = result.char_out;
  assign starts_token_o   = result.starts_token;
  assign kept_is_pipe_o   = result.kept_is_pipe;
  assign line_status_o    = result.line_status;

endmodule
